// ===== rtl/core/len_pkg.sv =====
// Shared types, constants and helper functions for the leader election node.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package len_pkg;

  localparam int MAX_NODES  = 8;
  localparam int TERM_BITS  = 32;
  localparam int NODE_SLOTS = 8;
  localparam int ACTIVE_CAP = (MAX_NODES < NODE_SLOTS) ? MAX_NODES : NODE_SLOTS;
  localparam int JOBQ_DEPTH = 4;
  localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);
  localparam int CFG_AW     = 5;

  localparam logic [2:0]  RST_SELF_ID    = 3'd0;
  localparam logic [3:0]  RST_NODE_COUNT = 4'd3;
  localparam logic [3:0]  RST_QUORUM     = 4'd2;
  localparam logic [15:0] RST_TO_BASE    = 16'd6000;
  localparam logic [15:0] RST_TO_SPREAD  = 16'd2047;
  localparam logic [15:0] RST_HB_PERIOD  = 16'd1000;
  localparam logic [15:0] RST_SEED       = 16'd44257;

  localparam logic [15:0] LFSR_TAPS = 16'hB400;
  localparam logic [15:0] MS_MAX    = 16'hFFFF;
  localparam logic [3:0]  COUNT_MAX = 4'd15;
  localparam logic [31:0] SELF_TAG  = 32'd1;

  typedef logic [TERM_BITS-1:0] term_t;

  typedef enum logic [1:0] {
    RL_FOLLOWER,
    RL_CANDIDATE,
    RL_LEADER
  } role_t;

  typedef enum logic [1:0] {
    FN_TICK,
    FN_VOTE_REQ,
    FN_HEARTBEAT,
    FN_VOTE_REPLY
  } func_t;

  typedef enum logic [1:0] {
    KD_VOTE_REQ,
    KD_HEARTBEAT,
    KD_VOTE_REPLY,
    KD_HB_ACK
  } kind_t;

  typedef enum logic [2:0] {
    RG_SELF_ID,
    RG_NODE_COUNT,
    RG_QUORUM,
    RG_TO_BASE,
    RG_TO_SPREAD,
    RG_HB_PERIOD,
    RG_SEED
  } cfg_reg_t;

  typedef struct packed {
    func_t       func;
    logic [31:0] msg_term;
    logic [2:0]  sender_id;
    logic        vote_granted;
    logic [31:0] request_tag;
  } item_t;

  typedef struct packed {
    logic                  bcast;
    kind_t                 kind;
    logic [2:0]            dest;
    logic                  granted;
    logic [31:0]           tag;
    term_t                 term;
    role_t                 role;
    logic                  leader_known;
    logic [2:0]            leader_node;
    logic [NODE_SLOTS-1:0] peers;
  } job_t;

  function automatic logic [15:0] new_timeout(input logic [15:0] base,
                                              input logic [15:0] spread,
                                              input logic [15:0] lfsr);
    logic [16:0] sum;
    sum = {1'b0, base} + {1'b0, lfsr & spread};
    return sum[16] ? MS_MAX : sum[15:0];
  endfunction

  function automatic logic [15:0] lfsr_step(input logic [15:0] v);
    logic [15:0] n;
    n = v[0] ? ((v >> 1) ^ LFSR_TAPS) : (v >> 1);
    return (n == 16'd0) ? 16'd1 : n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/len_front.sv =====
// Front end: configuration registers, election state and request classification.
// Depends on len_pkg; produces one job per request that causes results.
`default_nettype none

module len_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [len_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  input  logic                      acc,
  input  len_pkg::item_t            item,
  output logic                      job_vld,
  output len_pkg::job_t             job
);

  logic [2:0]  self_id_r, self_id_nxt;
  logic [3:0]  node_count_r, node_count_nxt;
  logic [3:0]  quorum_r, quorum_nxt;
  logic [15:0] to_base_r, to_base_nxt;
  logic [15:0] to_spread_r, to_spread_nxt;
  logic [15:0] hb_period_r, hb_period_nxt;
  logic [15:0] seed_r, seed_nxt;

  len_pkg::role_t role_r, role_nxt;
  len_pkg::term_t term_r, term_nxt;
  logic           voted_valid_r, voted_valid_nxt;
  logic [2:0]     voted_node_r, voted_node_nxt;
  logic           leader_valid_r, leader_valid_nxt;
  logic [2:0]     leader_idx_r, leader_idx_nxt;
  logic [15:0]    quiet_r, quiet_nxt;
  logic [15:0]    beat_r, beat_nxt;
  logic [15:0]    timeout_r, timeout_nxt;
  logic [15:0]    lfsr_r, lfsr_nxt;
  logic [3:0]     vote_count_r, vote_count_nxt;
  logic [len_pkg::NODE_SLOTS-1:0] voters_r, voters_nxt;

  logic                           cfg_wr;
  len_pkg::cfg_reg_t              cfg_idx;
  logic [15:0]                    seed_load;
  logic [3:0]                     n_act;
  logic [len_pkg::NODE_SLOTS-1:0] peers;
  logic [15:0]                    period;
  logic [15:0]                    quiet_inc;
  logic [15:0]                    beat_inc;
  logic [15:0]                    lfsr_adv;
  logic [3:0]                     count_inc;
  len_pkg::term_t                 msg_t;
  logic                           vv_eff;
  logic                           reply_ok;

  assign cfg_wr    = psel && penable && pwrite;
  assign cfg_idx   = len_pkg::cfg_reg_t'(paddr[4:2]);
  assign seed_load = (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];
  assign n_act     = (node_count_r > 4'(len_pkg::ACTIVE_CAP)) ?
                     4'(len_pkg::ACTIVE_CAP) : node_count_r;
  assign period    = (hb_period_r == 16'd0) ? 16'd1 : hb_period_r;
  assign quiet_inc = (quiet_r == len_pkg::MS_MAX) ? quiet_r : quiet_r + 16'd1;
  assign beat_inc  = (beat_r == len_pkg::MS_MAX) ? beat_r : beat_r + 16'd1;
  assign lfsr_adv  = len_pkg::lfsr_step(lfsr_r);
  assign count_inc = (vote_count_r == len_pkg::COUNT_MAX) ? vote_count_r :
                     vote_count_r + 4'd1;
  assign msg_t     = len_pkg::term_t'(item.msg_term);
  assign vv_eff    = (msg_t > term_r) ? 1'b0 : voted_valid_r;
  assign reply_ok  = (role_r == len_pkg::RL_CANDIDATE) && (msg_t == term_r) &&
                     item.vote_granted && (item.sender_id != self_id_r) &&
                     ({1'b0, item.sender_id} < n_act) && !voters_r[item.sender_id];

  always_comb begin
    for (int i = 0; i < len_pkg::NODE_SLOTS; i++) begin
      peers[i] = (4'(i) < n_act) && (3'(i) != self_id_r);
    end
  end

  always_comb begin
    case (cfg_idx)
      len_pkg::RG_SELF_ID:    prdata = {29'd0, self_id_r};
      len_pkg::RG_NODE_COUNT: prdata = {28'd0, node_count_r};
      len_pkg::RG_QUORUM:     prdata = {28'd0, quorum_r};
      len_pkg::RG_TO_BASE:    prdata = {16'd0, to_base_r};
      len_pkg::RG_TO_SPREAD:  prdata = {16'd0, to_spread_r};
      len_pkg::RG_HB_PERIOD:  prdata = {16'd0, hb_period_r};
      len_pkg::RG_SEED:       prdata = {16'd0, seed_r};
      default:                prdata = 32'd0;
    endcase
  end

  always_comb begin
    self_id_nxt      = self_id_r;
    node_count_nxt   = node_count_r;
    quorum_nxt       = quorum_r;
    to_base_nxt      = to_base_r;
    to_spread_nxt    = to_spread_r;
    hb_period_nxt    = hb_period_r;
    seed_nxt         = seed_r;
    role_nxt         = role_r;
    term_nxt         = term_r;
    voted_valid_nxt  = voted_valid_r;
    voted_node_nxt   = voted_node_r;
    leader_valid_nxt = leader_valid_r;
    leader_idx_nxt   = leader_idx_r;
    quiet_nxt        = quiet_r;
    beat_nxt         = beat_r;
    timeout_nxt      = timeout_r;
    lfsr_nxt         = lfsr_r;
    vote_count_nxt   = vote_count_r;
    voters_nxt       = voters_r;
    job_vld          = 1'b0;
    job              = '0;

    if (cfg_wr) begin
      case (cfg_idx)
        len_pkg::RG_SELF_ID:    self_id_nxt    = pwdata[2:0];
        len_pkg::RG_NODE_COUNT: node_count_nxt = pwdata[3:0];
        len_pkg::RG_QUORUM:     quorum_nxt     = pwdata[3:0];
        len_pkg::RG_TO_BASE: begin
          to_base_nxt = pwdata[15:0];
          timeout_nxt = len_pkg::new_timeout(pwdata[15:0], to_spread_r, lfsr_r);
        end
        len_pkg::RG_TO_SPREAD: begin
          to_spread_nxt = pwdata[15:0];
          timeout_nxt   = len_pkg::new_timeout(to_base_r, pwdata[15:0], lfsr_r);
        end
        len_pkg::RG_HB_PERIOD:  hb_period_nxt  = pwdata[15:0];
        len_pkg::RG_SEED: begin
          seed_nxt    = pwdata[15:0];
          lfsr_nxt    = seed_load;
          timeout_nxt = len_pkg::new_timeout(to_base_r, to_spread_r, seed_load);
        end
        default: ;
      endcase
    end else if (acc) begin
      case (item.func)
        len_pkg::FN_TICK: begin
          quiet_nxt = quiet_inc;
          if (role_r == len_pkg::RL_FOLLOWER) begin
            if (quiet_inc > timeout_r) begin
              role_nxt        = len_pkg::RL_CANDIDATE;
              term_nxt        = term_r + len_pkg::term_t'(1);
              voted_valid_nxt = 1'b1;
              voted_node_nxt  = self_id_r;
              vote_count_nxt  = 4'd1;
              voters_nxt      = len_pkg::NODE_SLOTS'(1) << self_id_r;
              quiet_nxt       = 16'd0;
              lfsr_nxt        = lfsr_adv;
              timeout_nxt     = len_pkg::new_timeout(to_base_r, to_spread_r, lfsr_adv);
              if (quorum_r <= 4'd1) begin
                role_nxt         = len_pkg::RL_LEADER;
                leader_valid_nxt = 1'b1;
                leader_idx_nxt   = self_id_r;
                beat_nxt         = 16'd0;
              end
              job_vld   = |peers;
              job.bcast = 1'b1;
              job.kind  = len_pkg::KD_VOTE_REQ;
              job.tag   = len_pkg::SELF_TAG;
            end
          end else if (role_r == len_pkg::RL_LEADER) begin
            beat_nxt = beat_inc;
            if (beat_inc >= period) begin
              beat_nxt  = 16'd0;
              job_vld   = |peers;
              job.bcast = 1'b1;
              job.kind  = len_pkg::KD_HEARTBEAT;
              job.tag   = len_pkg::SELF_TAG;
            end
          end
        end
        len_pkg::FN_VOTE_REQ: begin
          if (msg_t >= term_r) begin
            if (msg_t > term_r) begin
              term_nxt        = msg_t;
              role_nxt        = len_pkg::RL_FOLLOWER;
              voted_valid_nxt = 1'b0;
            end
            if (!vv_eff || (voted_node_r == item.sender_id)) begin
              voted_valid_nxt = 1'b1;
              voted_node_nxt  = item.sender_id;
              quiet_nxt       = 16'd0;
              role_nxt        = len_pkg::RL_FOLLOWER;
              job.granted     = 1'b1;
            end
          end
          job_vld  = 1'b1;
          job.kind = len_pkg::KD_VOTE_REPLY;
          job.dest = item.sender_id;
          job.tag  = item.request_tag;
        end
        len_pkg::FN_HEARTBEAT: begin
          if (msg_t >= term_r) begin
            term_nxt         = msg_t;
            quiet_nxt        = 16'd0;
            role_nxt         = len_pkg::RL_FOLLOWER;
            leader_valid_nxt = 1'b1;
            leader_idx_nxt   = item.sender_id;
          end
          job_vld  = 1'b1;
          job.kind = len_pkg::KD_HB_ACK;
          job.dest = item.sender_id;
          job.tag  = item.request_tag;
        end
        len_pkg::FN_VOTE_REPLY: begin
          if (reply_ok) begin
            voters_nxt     = voters_r | (len_pkg::NODE_SLOTS'(1) << item.sender_id);
            vote_count_nxt = count_inc;
            if (count_inc >= quorum_r) begin
              role_nxt         = len_pkg::RL_LEADER;
              leader_valid_nxt = 1'b1;
              leader_idx_nxt   = self_id_r;
              beat_nxt         = 16'd0;
            end
          end
        end
        default: ;
      endcase
    end

    job.term         = term_nxt;
    job.role         = role_nxt;
    job.leader_known = leader_valid_nxt;
    job.leader_node  = leader_idx_nxt;
    job.peers        = peers;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_id_r      <= len_pkg::RST_SELF_ID;
      node_count_r   <= len_pkg::RST_NODE_COUNT;
      quorum_r       <= len_pkg::RST_QUORUM;
      to_base_r      <= len_pkg::RST_TO_BASE;
      to_spread_r    <= len_pkg::RST_TO_SPREAD;
      hb_period_r    <= len_pkg::RST_HB_PERIOD;
      seed_r         <= len_pkg::RST_SEED;
      role_r         <= len_pkg::RL_FOLLOWER;
      term_r         <= '0;
      voted_valid_r  <= 1'b0;
      voted_node_r   <= 3'd0;
      leader_valid_r <= 1'b0;
      leader_idx_r   <= 3'd0;
      quiet_r        <= 16'd0;
      beat_r         <= 16'd0;
      timeout_r      <= len_pkg::new_timeout(len_pkg::RST_TO_BASE, len_pkg::RST_TO_SPREAD,
                                             len_pkg::RST_SEED);
      lfsr_r         <= len_pkg::RST_SEED;
      vote_count_r   <= 4'd0;
      voters_r       <= '0;
    end else begin
      self_id_r      <= self_id_nxt;
      node_count_r   <= node_count_nxt;
      quorum_r       <= quorum_nxt;
      to_base_r      <= to_base_nxt;
      to_spread_r    <= to_spread_nxt;
      hb_period_r    <= hb_period_nxt;
      seed_r         <= seed_nxt;
      role_r         <= role_nxt;
      term_r         <= term_nxt;
      voted_valid_r  <= voted_valid_nxt;
      voted_node_r   <= voted_node_nxt;
      leader_valid_r <= leader_valid_nxt;
      leader_idx_r   <= leader_idx_nxt;
      quiet_r        <= quiet_nxt;
      beat_r         <= beat_nxt;
      timeout_r      <= timeout_nxt;
      lfsr_r         <= lfsr_nxt;
      vote_count_r   <= vote_count_nxt;
      voters_r       <= voters_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/len_jobq.sv =====
// Short job queue between the front end and the back end.
// Depends on len_pkg for the job type and depth.
`default_nettype none

module len_jobq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  len_pkg::job_t din,
  output logic          full,
  input  logic          rd_en,
  output len_pkg::job_t dout,
  output logic          empty
);

  len_pkg::job_t                mem_r [len_pkg::JOBQ_DEPTH];
  logic [len_pkg::JOBQ_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [len_pkg::JOBQ_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [len_pkg::JOBQ_AW:0]    count_r, count_nxt;
  logic                         do_wr;
  logic                         do_rd;

  assign full  = (count_r == (len_pkg::JOBQ_AW + 1)'(len_pkg::JOBQ_DEPTH));
  assign empty = (count_r == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign dout  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + len_pkg::JOBQ_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + len_pkg::JOBQ_AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + (len_pkg::JOBQ_AW + 1)'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - (len_pkg::JOBQ_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/len_back.sv =====
// Back end: expands the head job into results, one per cycle while popped, peers lowest first.
// Depends on len_pkg; reads the job queue head.
`default_nettype none

module len_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_rdy,
  input  len_pkg::job_t       job,
  output logic                job_done,
  input  logic                pop,
  output logic                empty,
  output len_pkg::kind_t      kind,
  output logic [2:0]          dest_node,
  output logic [31:0]         term,
  output logic                granted,
  output logic [31:0]         tag,
  output logic                last,
  output len_pkg::role_t      node_role,
  output logic                leader_known,
  output logic [2:0]          leader_node
);

  logic [len_pkg::NODE_SLOTS-1:0] done_r, done_nxt;
  logic [len_pkg::NODE_SLOTS-1:0] rem;
  logic [len_pkg::NODE_SLOTS-1:0] pick;
  logic [2:0]                     sel;
  logic                           take;

  assign rem = job.peers & ~done_r;

  always_comb begin
    sel = 3'd0;
    for (int i = len_pkg::NODE_SLOTS - 1; i >= 0; i--) begin
      if (rem[i]) begin
        sel = 3'(i);
      end
    end
  end

  assign pick         = len_pkg::NODE_SLOTS'(1) << sel;
  assign empty        = !job_rdy;
  assign kind         = job.kind;
  assign dest_node    = job.bcast ? sel : job.dest;
  assign term         = 32'(job.term);
  assign granted      = job.granted;
  assign tag          = job.tag;
  assign last         = job.bcast ? ((rem & ~pick) == '0) : 1'b1;
  assign node_role    = job.role;
  assign leader_known = job.leader_known;
  assign leader_node  = job.leader_node;
  assign take         = pop && job_rdy;
  assign job_done     = take && last;

  always_comb begin
    done_nxt = done_r;
    if (take) begin
      done_nxt = last ? '0 : (done_r | pick);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
    end else begin
      done_r <= done_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/leader_election_node.sv =====
// Top level of the leader election node: front end, job queue and back end.
// Depends on len_pkg, len_front, len_jobq and len_back.
//
//   channel   ports              handshake                 width of request
//   input     in_*               push / full               func, term, id, flag, tag
//   result    out_*              pop / empty               9 fields, one message each
//   config    psel..prdata       APB write, pready tied    7 registers at 4*i
//
// The front end takes one request per cycle unless full and updates the election state in that cycle.
// Each request that causes messages leaves one job in a 4-entry queue.
// The back end gives one result per cycle while results are popped: one for a reply or ack,
// one per peer (up to 7) for a broadcast, so a broadcast holds the back end until its last result is popped.
// full rises only when 4 jobs wait; reset is synchronous and needs no clearing pass.
`default_nettype none

module leader_election_node (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_msg_term,
  input  logic [2:0]  in_sender_id,
  input  logic        in_vote_granted,
  input  logic [31:0] in_request_tag,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_kind,
  output logic [2:0]  out_dest_node,
  output logic [31:0] out_term,
  output logic        out_granted,
  output logic [31:0] out_tag,
  output logic        out_last,
  output logic [1:0]  out_node_role,
  output logic        out_leader_known,
  output logic [2:0]  out_leader_node,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  len_pkg::item_t item;
  len_pkg::job_t  fe_job;
  len_pkg::job_t  head_job;
  len_pkg::kind_t be_kind;
  len_pkg::role_t be_role;
  logic           acc;
  logic           fe_vld;
  logic           q_empty;
  logic           q_pop;

  assign pready            = 1'b1;
  assign acc               = push && !full;
  assign item.func         = len_pkg::func_t'(in_func);
  assign item.msg_term     = in_msg_term;
  assign item.sender_id    = in_sender_id;
  assign item.vote_granted = in_vote_granted;
  assign item.request_tag  = in_request_tag;
  assign out_kind          = 2'(be_kind);
  assign out_node_role     = 2'(be_role);

  len_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .acc     (acc),
    .item    (item),
    .job_vld (fe_vld),
    .job     (fe_job)
  );

  len_jobq u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (fe_vld),
    .din   (fe_job),
    .full  (full),
    .rd_en (q_pop),
    .dout  (head_job),
    .empty (q_empty)
  );

  len_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_rdy      (!q_empty),
    .job          (head_job),
    .job_done     (q_pop),
    .pop          (pop),
    .empty        (empty),
    .kind         (be_kind),
    .dest_node    (out_dest_node),
    .term         (out_term),
    .granted      (out_granted),
    .tag          (out_tag),
    .last         (out_last),
    .node_role    (be_role),
    .leader_known (out_leader_known),
    .leader_node  (out_leader_node)
  );

endmodule

`default_nettype wire

// ===== rtl/core/len_chk.sv =====
// Port-level checks for the leader election node, bound to the top level.
// Depends on len_pkg for the message kind and role codes.
`default_nettype none

module len_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  out_kind,
  input logic [2:0]  out_dest_node,
  input logic [31:0] out_term,
  input logic        out_granted,
  input logic        out_last,
  input logic [1:0]  out_node_role,
  input logic        out_leader_known
);

  // hold a waiting result until it is popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_kind) && $stable(out_dest_node) &&
                          $stable(out_term) && $stable(out_last)))
    else $error("waiting result changed before pop");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> empty)
    else $error("result queue not empty after reset");

  // replies and acks are single results
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_kind == len_pkg::KD_VOTE_REPLY || out_kind == len_pkg::KD_HB_ACK))
      |-> out_last)
    else $error("reply or ack not marked last");

  a_granted: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_granted) |-> (out_kind == len_pkg::KD_VOTE_REPLY))
    else $error("granted set on a non-reply");

  a_leader: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_node_role == len_pkg::RL_LEADER) |-> out_leader_known)
    else $error("leader role without a recorded leader");

endmodule

bind leader_election_node len_chk u_len_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .empty            (empty),
  .pop              (pop),
  .out_kind         (out_kind),
  .out_dest_node    (out_dest_node),
  .out_term         (out_term),
  .out_granted      (out_granted),
  .out_last         (out_last),
  .out_node_role    (out_node_role),
  .out_leader_known (out_leader_known)
);

`default_nettype wire
